@@ rtl/prs_pkg.sv @@
package prs_pkg;

	// Coordinate format: signed fixed point, CW bits with FB fraction bits
	localparam int CW    = 24;
	localparam int FB    = 8;
	// Gain and register widths
	localparam int GW    = 32;
	localparam int FW    = 17;
	// Squared distance, exact
	localparam int D2W   = 2 * CW + 1;
	// Push numerator shift and quotient width (cap is 2^(FQW-1))
	localparam int SHIFT = 3 * FB;
	localparam int FQW   = 47;
	// Root width and unit-vector quotient width (u <= 2^USH)
	localparam int RW    = (D2W + 1) / 2;
	localparam int USH   = 16;
	localparam int UW    = USH + 1;
	// Ease term width (signed)
	localparam int EW    = CW + 2;
	// Back-end iterative pipeline: push divider length, unit divider start
	localparam int NSTG    = FQW;
	localparam int U_START = RW;
	// Queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	localparam logic [GW-1:0] FIXED_GAIN = GW'(3000);
	localparam logic [FW-1:0] FIXED_FRIC = FW'(58982);
	localparam logic [FW-1:0] FIXED_EASE = FW'(6554);

	typedef enum logic [1:0] {
		MODE_LATCH  = 2'd0,
		MODE_RADIUS = 2'd1,
		MODE_FIXED  = 2'd2,
		MODE_BUTTON = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CFG_MODE = 2'd0,
		CFG_FRIC = 2'd1,
		CFG_EASE = 2'd2,
		CFG_THR  = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		mode_t          mode;
		logic [FW-1:0]  fric;
		logic [FW-1:0]  ease;
		logic [GW-1:0]  thr;
	} cfg_t;

	// One classified particle, front to back
	typedef struct packed {
		logic signed [CW-1:0] pos_x;
		logic signed [CW-1:0] pos_y;
		logic signed [CW-1:0] vel_x;
		logic signed [CW-1:0] vel_y;
		logic [D2W-1:0]       d2;
		logic [CW-1:0]        mdx;
		logic [CW-1:0]        mdy;
		logic                 dxp;
		logic                 dyp;
		logic signed [EW-1:0] ex;
		logic signed [EW-1:0] ey;
		logic                 push;
		logic                 active;
		logic                 tout;
	} item_t;

	// Modes 0 and 1 take gains from the registers
	function automatic logic uses_regs(input mode_t m);
		return (m == MODE_LATCH) || (m == MODE_RADIUS);
	endfunction

endpackage

@@ rtl/particle_repel_ease_step.sv @@
// Particle update with cursor repulsion and spring return to home, Q15.8.
// One particle beat is accepted per clock and one result beat leaves per
// clock when neither side stalls. A particle passes three front stages
// (difference, squares, distance compare), the four-entry queue, 47
// back-end stages, one per push quotient bit, with the square root and
// unit-vector quotients alongside, and six stages for push, friction and
// position. Configuration registers are written through the cfg channel
// (always ready); the user must write them only while no particle is in
// flight, and the block does not enforce this.
module particle_repel_ease_step (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [31:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [prs_pkg::CW-1:0] pos_x,
	input  logic signed [prs_pkg::CW-1:0] pos_y,
	input  logic signed [prs_pkg::CW-1:0] vel_x,
	input  logic signed [prs_pkg::CW-1:0] vel_y,
	input  logic signed [prs_pkg::CW-1:0] home_x,
	input  logic signed [prs_pkg::CW-1:0] home_y,
	input  logic                          touched_in,
	input  logic signed [prs_pkg::CW-1:0] cursor_x,
	input  logic signed [prs_pkg::CW-1:0] cursor_y,
	input  logic                          button_down,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [prs_pkg::CW-1:0] new_pos_x,
	output logic signed [prs_pkg::CW-1:0] new_pos_y,
	output logic signed [prs_pkg::CW-1:0] new_vel_x,
	output logic signed [prs_pkg::CW-1:0] new_vel_y,
	output logic                          touched_out
);

	prs_pkg::cfg_t   cfg_q;
	prs_pkg::item_t  q_item, q_head;
	logic            q_push, q_pop, q_full, q_empty;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= prs_pkg::MODE_BUTTON;
			cfg_q.fric <= prs_pkg::FIXED_FRIC;
			cfg_q.ease <= prs_pkg::FIXED_EASE;
			cfg_q.thr  <= prs_pkg::GW'(6400);
		end else if (cfg_valid && cfg_ready) begin
			unique case (prs_pkg::cfg_idx_t'(cfg_index))
				prs_pkg::CFG_MODE: cfg_q.mode <= prs_pkg::mode_t'(cfg_data[1:0]);
				prs_pkg::CFG_FRIC: cfg_q.fric <= cfg_data[prs_pkg::FW-1:0];
				prs_pkg::CFG_EASE: cfg_q.ease <= cfg_data[prs_pkg::FW-1:0];
				prs_pkg::CFG_THR:  cfg_q.thr  <= cfg_data[prs_pkg::GW-1:0];
			endcase
		end
	end

	prs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.vel_x       (vel_x),
		.vel_y       (vel_y),
		.home_x      (home_x),
		.home_y      (home_y),
		.touched_in  (touched_in),
		.cursor_x    (cursor_x),
		.cursor_y    (cursor_y),
		.button_down (button_down),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_item      (q_item)
	);

	prs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.pop       (q_pop),
		.head      (q_head),
		.full      (q_full),
		.empty     (q_empty)
	);

	prs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.new_pos_x   (new_pos_x),
		.new_pos_y   (new_pos_y),
		.new_vel_x   (new_vel_x),
		.new_vel_y   (new_vel_y),
		.touched_out (touched_out)
	);

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full)) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_empty)) else $error("queue read while empty");
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> q_full) else $error("input stalled with queue space");
`endif

endmodule

@@ rtl/prs_queue.sv @@
module prs_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  prs_pkg::item_t  push_item,
	input  logic            pop,
	output prs_pkg::item_t  head,
	output logic            full,
	output logic            empty
);

	prs_pkg::item_t               mem_q [prs_pkg::QDEPTH];
	logic [prs_pkg::QAW-1:0]      wr_q;
	logic [prs_pkg::QAW-1:0]      rd_q;
	logic [prs_pkg::QAW:0]        cnt_q;

	assign full  = (cnt_q == (prs_pkg::QAW+1)'(prs_pkg::QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

endmodule

@@ rtl/prs_front.sv @@
module prs_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  prs_pkg::cfg_t                 cfg,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [prs_pkg::CW-1:0] pos_x,
	input  logic signed [prs_pkg::CW-1:0] pos_y,
	input  logic signed [prs_pkg::CW-1:0] vel_x,
	input  logic signed [prs_pkg::CW-1:0] vel_y,
	input  logic signed [prs_pkg::CW-1:0] home_x,
	input  logic signed [prs_pkg::CW-1:0] home_y,
	input  logic                          touched_in,
	input  logic signed [prs_pkg::CW-1:0] cursor_x,
	input  logic signed [prs_pkg::CW-1:0] cursor_y,
	input  logic                          button_down,
	input  logic                          q_full,
	output logic                          q_push,
	output prs_pkg::item_t                q_item
);

	localparam int CW   = prs_pkg::CW;
	localparam int FW   = prs_pkg::FW;
	localparam int D2W  = prs_pkg::D2W;
	localparam int PW   = CW + FW;
	localparam int EW_L = prs_pkg::EW;

	logic en;

	// stage 1: differences
	logic signed [CW:0] dx, dy, hx, hy;
	logic [CW:0]        ndx, ndy, nhx, nhy;

	logic                 vld_s1;
	logic signed [CW-1:0] px_s1, py_s1, vx_s1, vy_s1;
	logic [CW-1:0]        mdx_s1, mdy_s1, mhx_s1, mhy_s1;
	logic                 dxp_s1, dyp_s1, hxn_s1, hyn_s1, tin_s1, btn_s1;

	// stage 2: squares and ease products
	logic [FW-1:0]        ease_sel;
	logic                 vld_s2;
	logic signed [CW-1:0] px_s2, py_s2, vx_s2, vy_s2;
	logic [CW-1:0]        mdx_s2, mdy_s2;
	logic                 dxp_s2, dyp_s2, hxn_s2, hyn_s2, tin_s2, btn_s2;
	logic [2*CW-1:0]      sqx_s2, sqy_s2;
	logic [PW-1:0]        epx_s2, epy_s2;

	// stage 3: distance, classification, ease rounding
	logic [D2W-1:0]       d2;
	logic                 near, act, psh, tout;
	logic [PW-1:0]        erx, ery;
	logic [EW_L-1:0]      emx, emy;
	logic signed [EW_L-1:0] esx, esy;

	logic                 vld_s3;
	prs_pkg::item_t       item_s3;

	assign en       = !(vld_s3 && q_full);
	assign in_stall = vld_s3 && q_full;
	assign q_push   = vld_s3 && !q_full;
	assign q_item   = item_s3;

	always_comb begin
		dx  = $signed({cursor_x[CW-1], cursor_x}) - $signed({pos_x[CW-1], pos_x});
		dy  = $signed({cursor_y[CW-1], cursor_y}) - $signed({pos_y[CW-1], pos_y});
		hx  = $signed({home_x[CW-1], home_x}) - $signed({pos_x[CW-1], pos_x});
		hy  = $signed({home_y[CW-1], home_y}) - $signed({pos_y[CW-1], pos_y});
		ndx = -dx;
		ndy = -dy;
		nhx = -hx;
		nhy = -hy;
	end

	assign ease_sel = prs_pkg::uses_regs(cfg.mode) ? cfg.ease : prs_pkg::FIXED_EASE;

	always_comb begin
		d2   = {1'b0, sqx_s2} + {1'b0, sqy_s2};
		near = 64'(d2) < 64'({cfg.thr, {(2*prs_pkg::FB){1'b0}}});
		tout = tin_s2;
		act  = 1'b1;
		psh  = near;
		unique case (cfg.mode) inside
			prs_pkg::MODE_LATCH: begin
				tout = tin_s2 || near;
				act  = tin_s2 || near;
				psh  = 1'b0;
			end
			prs_pkg::MODE_BUTTON: begin
				act = btn_s2;
				psh = btn_s2 && near;
			end
			prs_pkg::MODE_RADIUS, prs_pkg::MODE_FIXED: begin
				act = 1'b1;
				psh = near;
			end
		endcase
		// round half away from zero on magnitude
		erx = epx_s2 + PW'(32768);
		ery = epy_s2 + PW'(32768);
		emx = EW_L'(erx[PW-1:16]);
		emy = EW_L'(ery[PW-1:16]);
		esx = hxn_s2 ? -$signed(emx) : $signed(emx);
		esy = hyn_s2 ? -$signed(emy) : $signed(emy);
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			px_s1  <= pos_x;
			py_s1  <= pos_y;
			vx_s1  <= vel_x;
			vy_s1  <= vel_y;
			mdx_s1 <= dx[CW] ? ndx[CW-1:0] : dx[CW-1:0];
			mdy_s1 <= dy[CW] ? ndy[CW-1:0] : dy[CW-1:0];
			mhx_s1 <= hx[CW] ? nhx[CW-1:0] : hx[CW-1:0];
			mhy_s1 <= hy[CW] ? nhy[CW-1:0] : hy[CW-1:0];
			dxp_s1 <= !dx[CW] && (dx != '0);
			dyp_s1 <= !dy[CW] && (dy != '0);
			hxn_s1 <= hx[CW];
			hyn_s1 <= hy[CW];
			tin_s1 <= touched_in;
			btn_s1 <= button_down;

			px_s2  <= px_s1;
			py_s2  <= py_s1;
			vx_s2  <= vx_s1;
			vy_s2  <= vy_s1;
			mdx_s2 <= mdx_s1;
			mdy_s2 <= mdy_s1;
			dxp_s2 <= dxp_s1;
			dyp_s2 <= dyp_s1;
			hxn_s2 <= hxn_s1;
			hyn_s2 <= hyn_s1;
			tin_s2 <= tin_s1;
			btn_s2 <= btn_s1;
			sqx_s2 <= mdx_s1 * mdx_s1;
			sqy_s2 <= mdy_s1 * mdy_s1;
			epx_s2 <= mhx_s1 * ease_sel;
			epy_s2 <= mhy_s1 * ease_sel;

			item_s3.pos_x  <= px_s2;
			item_s3.pos_y  <= py_s2;
			item_s3.vel_x  <= vx_s2;
			item_s3.vel_y  <= vy_s2;
			item_s3.d2     <= d2;
			item_s3.mdx    <= mdx_s2;
			item_s3.mdy    <= mdy_s2;
			item_s3.dxp    <= dxp_s2;
			item_s3.dyp    <= dyp_s2;
			item_s3.ex     <= esx;
			item_s3.ey     <= esy;
			item_s3.push   <= psh && (d2 != '0);
			item_s3.active <= act;
			item_s3.tout   <= tout;
		end
	end

endmodule

@@ rtl/prs_back.sv @@
module prs_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  prs_pkg::cfg_t                 cfg,
	input  logic                          q_empty,
	input  prs_pkg::item_t                q_head,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [prs_pkg::CW-1:0] new_pos_x,
	output logic signed [prs_pkg::CW-1:0] new_pos_y,
	output logic signed [prs_pkg::CW-1:0] new_vel_x,
	output logic signed [prs_pkg::CW-1:0] new_vel_y,
	output logic                          touched_out
);

	localparam int CW    = prs_pkg::CW;
	localparam int GW    = prs_pkg::GW;
	localparam int FW    = prs_pkg::FW;
	localparam int D2W   = prs_pkg::D2W;
	localparam int SHIFT = prs_pkg::SHIFT;
	localparam int FQW   = prs_pkg::FQW;
	localparam int RW    = prs_pkg::RW;
	localparam int UW    = prs_pkg::UW;
	localparam int USH   = prs_pkg::USH;
	localparam int EW    = prs_pkg::EW;
	localparam int NSTG  = prs_pkg::NSTG;
	localparam int USTA  = prs_pkg::U_START;
	localparam int FLW   = 24;
	localparam int FHW   = FQW - FLW;
	localparam int MW    = FQW + UW - USH;
	localparam int SATW  = MW + 2;
	localparam int PW    = CW + FW;
	localparam logic [FQW-1:0] CAPV = {1'b1, {(FQW-1){1'b0}}};

	typedef struct packed {
		prs_pkg::item_t  it;
		logic            ovf;
		logic [D2W-1:0]  frem;
		logic [FQW-1:0]  fq;
		logic [RW:0]     srem;
		logic [RW-1:0]   sroot;
		logic [RW-1:0]   uxr;
		logic [UW-1:0]   uxq;
		logic [RW-1:0]   uyr;
		logic [UW-1:0]   uyq;
	} stg_t;

	function automatic logic signed [CW-1:0] sat(input logic signed [SATW-1:0] v);
		logic signed [SATW-1:0] hi, lo;
		hi = $signed({{(SATW-CW+1){1'b0}}, {(CW-1){1'b1}}});
		lo = $signed({{(SATW-CW+1){1'b1}}, {(CW-1){1'b0}}});
		if (v > hi)      return hi[CW-1:0];
		else if (v < lo) return lo[CW-1:0];
		else             return v[CW-1:0];
	endfunction

	logic           en;
	logic [GW-1:0]  gain;
	logic [FW-1:0]  fric;
	logic [GW-1:0]  ghead;
	stg_t           init_st;
	stg_t           stg_s [NSTG];
	logic           vld_s [NSTG];

	assign en    = !(out_valid && out_stall);
	assign q_pop = en && !q_empty;
	assign gain  = prs_pkg::uses_regs(cfg.mode) ? cfg.thr : prs_pkg::FIXED_GAIN;
	assign fric  = prs_pkg::uses_regs(cfg.mode) ? cfg.fric : prs_pkg::FIXED_FRIC;
	assign ghead = gain >> (FQW - SHIFT);

	// divider entry: quotient bits above the cap are settled by one compare
	always_comb begin
		init_st       = '0;
		init_st.it    = q_head;
		init_st.frem  = {{(D2W-GW){1'b0}}, ghead};
		init_st.ovf   = {{(D2W-GW){1'b0}}, ghead} >= q_head.d2;
	end

	// Iterative pipeline: push quotient one bit per stage, root one bit per
	// stage, then unit-vector quotients one bit per stage.
	for (genvar gi = 0; gi < NSTG; gi++) begin : g_stg
		localparam int  FBI  = FQW - 1 - gi;
		localparam bit  DO_SQ = (gi < RW);
		localparam bit  DO_U  = (gi >= USTA) && (gi < USTA + UW);

		stg_t          cur, nxt;
		logic          vin;
		logic          fbit;
		logic [1:0]    spair;
		logic          ubx, uby;
		logic [RW-1:0] urx, ury;
		logic [D2W:0]  fcat, fdif;
		logic [RW+2:0] scat, strial, sdif;
		logic [RW:0]   ucx, ucy, udx, udy;

		if (gi == 0) begin : g_first
			assign cur = init_st;
			assign vin = !q_empty;
		end else begin : g_next
			assign cur = stg_s[gi-1];
			assign vin = vld_s[gi-1];
		end

		if (FBI >= SHIFT) begin : g_fb
			assign fbit = gain[FBI-SHIFT];
		end else begin : g_fz
			assign fbit = 1'b0;
		end

		if (DO_SQ) begin : g_sq
			logic [2*RW-1:0] sd2;
			assign sd2   = (2*RW)'(cur.it.d2);
			assign spair = sd2[2*(RW-1-gi)+1 -: 2];
		end else begin : g_nsq
			assign spair = 2'b00;
		end

		if (gi == USTA) begin : g_u0
			assign ubx = cur.it.mdx[0];
			assign uby = cur.it.mdy[0];
			assign urx = RW'(cur.it.mdx >> 1);
			assign ury = RW'(cur.it.mdy >> 1);
		end else begin : g_un
			assign ubx = 1'b0;
			assign uby = 1'b0;
			assign urx = cur.uxr;
			assign ury = cur.uyr;
		end

		always_comb begin
			nxt = cur;
			// push quotient step
			fcat = {cur.frem, fbit};
			fdif = fcat - {1'b0, cur.it.d2};
			if (fcat >= {1'b0, cur.it.d2}) begin
				nxt.frem = fdif[D2W-1:0];
				nxt.fq   = {cur.fq[FQW-2:0], 1'b1};
			end else begin
				nxt.frem = fcat[D2W-1:0];
				nxt.fq   = {cur.fq[FQW-2:0], 1'b0};
			end
			// root digit step
			scat   = {cur.srem, spair};
			strial = {1'b0, cur.sroot, 2'b01};
			sdif   = scat - strial;
			if (DO_SQ) begin
				if (scat >= strial) begin
					nxt.srem  = sdif[RW:0];
					nxt.sroot = {cur.sroot[RW-2:0], 1'b1};
				end else begin
					nxt.srem  = scat[RW:0];
					nxt.sroot = {cur.sroot[RW-2:0], 1'b0};
				end
			end
			// unit-vector quotient steps
			ucx = {urx, ubx};
			ucy = {ury, uby};
			udx = ucx - {1'b0, cur.sroot};
			udy = ucy - {1'b0, cur.sroot};
			if (DO_U) begin
				if (ucx >= {1'b0, cur.sroot}) begin
					nxt.uxr = udx[RW-1:0];
					nxt.uxq = {cur.uxq[UW-2:0], 1'b1};
				end else begin
					nxt.uxr = ucx[RW-1:0];
					nxt.uxq = {cur.uxq[UW-2:0], 1'b0};
				end
				if (ucy >= {1'b0, cur.sroot}) begin
					nxt.uyr = udy[RW-1:0];
					nxt.uyq = {cur.uyq[UW-2:0], 1'b1};
				end else begin
					nxt.uyr = ucy[RW-1:0];
					nxt.uyq = {cur.uyq[UW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[gi] <= 1'b0;
			else if (en) vld_s[gi] <= vin;
		end

		always_ff @(posedge clk) begin
			if (en) stg_s[gi] <= nxt;
		end
	end

	// tail: cap, push products, push apply, friction, position
	stg_t           last;
	logic [FQW-1:0] fsel;
	assign last = stg_s[NSTG-1];
	assign fsel = (last.ovf || (last.fq > CAPV)) ? CAPV : last.fq;

	logic                 vld_s48, vld_s49, vld_s50, vld_s51, vld_s52, vld_s53;
	prs_pkg::item_t       it_s48, it_s49, it_s50, it_s51, it_s52;
	logic [FLW+UW-1:0]    plx_s48, ply_s48;
	logic [FHW+UW-1:0]    phx_s48, phy_s48;
	logic [MW-1:0]        mx_s49, my_s49;
	logic signed [CW-1:0] vpx_s50, vpy_s50;
	logic [PW-1:0]        fpx_s51, fpy_s51;
	logic                 fnx_s51, fny_s51;
	logic signed [CW-1:0] vfx_s52, vfy_s52;

	logic [FQW+UW-1:0]    smx, smy;
	logic signed [SATW-1:0] vsx, vsy;
	logic [CW:0]          nvx, nvy;
	logic [PW-1:0]        rpx, rpy;
	logic signed [FW+9:0] rsx, rsy;
	logic signed [SATW-1:0] psx, psy;

	always_comb begin
		smx = {phx_s48, {FLW{1'b0}}} + (FQW+UW)'(plx_s48);
		smy = {phy_s48, {FLW{1'b0}}} + (FQW+UW)'(ply_s48);
		vsx = it_s49.dxp ? SATW'(it_s49.vel_x) - $signed({2'b00, mx_s49})
		                 : SATW'(it_s49.vel_x) + $signed({2'b00, mx_s49});
		vsy = it_s49.dyp ? SATW'(it_s49.vel_y) - $signed({2'b00, my_s49})
		                 : SATW'(it_s49.vel_y) + $signed({2'b00, my_s49});
		nvx = -{vpx_s50[CW-1], vpx_s50};
		nvy = -{vpy_s50[CW-1], vpy_s50};
		rpx = fpx_s51 + PW'(32768);
		rpy = fpy_s51 + PW'(32768);
		rsx = fnx_s51 ? -$signed({1'b0, rpx[PW-1:16]}) : $signed({1'b0, rpx[PW-1:16]});
		rsy = fny_s51 ? -$signed({1'b0, rpy[PW-1:16]}) : $signed({1'b0, rpy[PW-1:16]});
		psx = SATW'(it_s52.pos_x) + SATW'(vfx_s52) + SATW'(it_s52.ex);
		psy = SATW'(it_s52.pos_y) + SATW'(vfy_s52) + SATW'(it_s52.ey);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s48 <= 1'b0;
			vld_s49 <= 1'b0;
			vld_s50 <= 1'b0;
			vld_s51 <= 1'b0;
			vld_s52 <= 1'b0;
			vld_s53 <= 1'b0;
		end else if (en) begin
			vld_s48 <= vld_s[NSTG-1];
			vld_s49 <= vld_s48;
			vld_s50 <= vld_s49;
			vld_s51 <= vld_s50;
			vld_s52 <= vld_s51;
			vld_s53 <= vld_s52;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// push magnitude times unit component, split into two products
			it_s48  <= last.it;
			plx_s48 <= fsel[FLW-1:0] * last.uxq;
			ply_s48 <= fsel[FLW-1:0] * last.uyq;
			phx_s48 <= fsel[FQW-1:FLW] * last.uxq;
			phy_s48 <= fsel[FQW-1:FLW] * last.uyq;

			it_s49 <= it_s48;
			mx_s49 <= smx[FQW+UW-1:USH];
			my_s49 <= smy[FQW+UW-1:USH];

			it_s50  <= it_s49;
			vpx_s50 <= it_s49.push ? sat(vsx) : it_s49.vel_x;
			vpy_s50 <= it_s49.push ? sat(vsy) : it_s49.vel_y;

			// friction
			it_s51  <= it_s50;
			fpx_s51 <= (vpx_s50[CW-1] ? nvx[CW-1:0] : vpx_s50) * fric;
			fpy_s51 <= (vpy_s50[CW-1] ? nvy[CW-1:0] : vpy_s50) * fric;
			fnx_s51 <= vpx_s50[CW-1];
			fny_s51 <= vpy_s50[CW-1];

			it_s52  <= it_s51;
			vfx_s52 <= sat(SATW'(rsx));
			vfy_s52 <= sat(SATW'(rsy));

			// output beat
			touched_out <= it_s52.tout;
			if (it_s52.active) begin
				new_pos_x <= sat(psx);
				new_pos_y <= sat(psy);
				new_vel_x <= vfx_s52;
				new_vel_y <= vfy_s52;
			end else begin
				new_pos_x <= it_s52.pos_x;
				new_pos_y <= it_s52.pos_y;
				new_vel_x <= it_s52.vel_x;
				new_vel_y <= it_s52.vel_y;
			end
		end
	end

	assign out_valid = vld_s53;

endmodule

@@ test/particle_repel_ease_step_test.sv @@
import prs_pkg::*;

typedef struct {
	logic signed [CW-1:0] pos_x, pos_y, vel_x, vel_y, home_x, home_y;
	logic                 touched_in;
	logic signed [CW-1:0] cursor_x, cursor_y;
	logic                 button_down;
} particle_in_t;

typedef struct packed {
	logic signed [CW-1:0] pos_x, pos_y, vel_x, vel_y;
	logic                 touched;
} particle_out_t;

// Predicts each particle update and checks results in order
class particle_scoreboard;
	mode_t                mode_r;
	logic [FW-1:0]        fric_r;
	logic [FW-1:0]        ease_r;
	logic [GW-1:0]        thr_r;
	particle_out_t        expected_q[$];
	int                   errors;

	function new();
		mode_r = MODE_BUTTON;
		fric_r = FW'(58982);
		ease_r = FW'(6554);
		thr_r = GW'(6400);
		errors = 0;
	endfunction

	function void set_reg(cfg_idx_t idx, logic [31:0] val);
		case (idx)
			CFG_MODE: mode_r = mode_t'(val[1:0]);
			CFG_FRIC: fric_r = val[FW-1:0];
			CFG_EASE: ease_r = val[FW-1:0];
			CFG_THR:  thr_r = val;
		endcase
	endfunction

	function longint sat(longint v);
		longint hi;
		hi = (longint'(1) <<< (CW - 1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	// Q1.16 scaling, rounded half away from zero
	function longint gain_round(longint v, longint unsigned g);
		longint unsigned m;
		m = ((v < 0 ? -v : v) * g + 32768) >> 16;
		return v < 0 ? -longint'(m) : longint'(m);
	endfunction

	function longint unsigned root_floor(longint unsigned x);
		longint unsigned r, t;
		r = 0;
		for (int i = 31; i >= 0; i--) begin
			t = r | (longint'(1) << i);
			if (t * t <= x) r = t;
		end
		return r;
	endfunction

	// Velocity after push along one axis, pointing away from the cursor
	function longint push_axis(longint v, longint d, longint unsigned f,
			longint unsigned r);
		longint unsigned u;
		longint m;
		u = ((d < 0 ? -d : d) << 16) / r;
		m = longint'((f * u) >> 16);
		return sat(d > 0 ? v - m : v + m);
	endfunction

	function void note_particle(particle_in_t p);
		longint px, py, vx, vy, dx, dy;
		longint unsigned d2, g, fr, es, f, r, cap;
		logic near, active, push, tout;
		particle_out_t e;
		px = p.pos_x; py = p.pos_y; vx = p.vel_x; vy = p.vel_y;
		dx = longint'(p.cursor_x) - px;
		dy = longint'(p.cursor_y) - py;
		d2 = dx * dx + dy * dy;
		near = d2 < (longint'(thr_r) << (2 * FB));
		tout = p.touched_in;
		if (mode_r == MODE_LATCH || mode_r == MODE_RADIUS) begin
			fr = fric_r; es = ease_r; g = thr_r;
		end else begin
			fr = 58982; es = 6554; g = 3000;
		end
		case (mode_r)
			MODE_LATCH: begin
				tout = p.touched_in | near;
				active = tout;
				push = 0;
			end
			MODE_BUTTON: begin
				active = p.button_down;
				push = p.button_down & near;
			end
			default: begin
				active = 1;
				push = near;
			end
		endcase
		if (active) begin
			if (push && d2 != 0) begin
				cap = longint'(1) << 46;
				f = (g << (3 * FB)) / d2;
				if (f > cap) f = cap;
				r = root_floor(d2);
				vx = push_axis(vx, dx, f, r);
				vy = push_axis(vy, dy, f, r);
			end
			vx = sat(gain_round(vx, fr));
			vy = sat(gain_round(vy, fr));
			px = sat(px + vx + gain_round(longint'(p.home_x) - px, es));
			py = sat(py + vy + gain_round(longint'(p.home_y) - py, es));
		end
		e.pos_x = px[CW-1:0]; e.pos_y = py[CW-1:0];
		e.vel_x = vx[CW-1:0]; e.vel_y = vy[CW-1:0];
		e.touched = tout;
		expected_q.push_back(e);
	endfunction

	function void check_particle(particle_out_t a);
		particle_out_t e;
		if (expected_q.size() == 0) begin
			errors++;
			if (errors <= 10) $display("unexpected result beat");
			return;
		end
		e = expected_q.pop_front();
		if (a !== e) begin
			errors++;
			if (errors <= 10)
				$display({"mismatch: exp pos %0d,%0d vel %0d,%0d t %0b",
					" / got pos %0d,%0d vel %0d,%0d t %0b"},
					e.pos_x, e.pos_y, e.vel_x, e.vel_y, e.touched,
					a.pos_x, a.pos_y, a.vel_x, a.vel_y, a.touched);
		end
	endfunction
endclass

module particle_repel_ease_step_test;
	localparam int WATCHDOG = 5000;
	localparam int DRAIN = 70;

	logic                 clk = 0;
	logic                 arst_n;
	logic                 cfg_valid, cfg_ready;
	cfg_idx_t             cfg_index;
	logic [31:0]          cfg_data;
	logic                 in_valid, in_stall;
	logic signed [CW-1:0] pos_x, pos_y, vel_x, vel_y, home_x, home_y;
	logic                 touched_in;
	logic signed [CW-1:0] cursor_x, cursor_y;
	logic                 button_down;
	logic                 out_valid, out_stall;
	logic signed [CW-1:0] new_pos_x, new_pos_y, new_vel_x, new_vel_y;
	logic                 touched_out;

	particle_scoreboard sb = new();
	int hold_cycles = 0;
	bit idle_on = 1;
	int quiet = 0;

	particle_repel_ease_step dut (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// Watchdog: cycles without any accepted beat
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Result side: random stalls, one long hold on request
	initial begin
		int n;
		particle_out_t a;
		out_stall = 0;
		@(posedge arst_n);
		forever begin
			n = idle_on ? $urandom_range(0, 6) : 0;
			if (hold_cycles > 0) begin
				n = hold_cycles;
				hold_cycles = 0;
			end
			if (n > 0) begin
				out_stall <= 1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 0;
			do @(posedge clk); while (!out_valid);
			a.pos_x = new_pos_x; a.pos_y = new_pos_y;
			a.vel_x = new_vel_x; a.vel_y = new_vel_y;
			a.touched = touched_out;
			sb.check_particle(a);
		end
	end

	task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
	endtask

	task automatic set_config(logic [1:0] m, logic [31:0] fr, logic [31:0] es,
			logic [31:0] thr);
		write_reg(CFG_MODE, {30'd0, m});
		write_reg(CFG_FRIC, fr);
		write_reg(CFG_EASE, es);
		write_reg(CFG_THR, thr);
		cfg_valid <= 0;
	endtask

	task automatic send_particle(particle_in_t p);
		int gap;
		gap = idle_on ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		pos_x <= p.pos_x; pos_y <= p.pos_y;
		vel_x <= p.vel_x; vel_y <= p.vel_y;
		home_x <= p.home_x; home_y <= p.home_y;
		touched_in <= p.touched_in;
		cursor_x <= p.cursor_x; cursor_y <= p.cursor_y;
		button_down <= p.button_down;
		do @(posedge clk); while (in_stall);
		sb.note_particle(p);
	endtask

	// Quiet the pipeline before touching registers
	task automatic drain();
		in_valid <= 0;
		while (sb.expected_q.size() > 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	function automatic logic signed [CW-1:0] any_coord();
		case ($urandom_range(0, 5))
			0: return {1'b0, {(CW-1){1'b1}}};
			1: return {1'b1, {(CW-1){1'b0}}};
			2: return CW'($signed($urandom_range(0, 8191)) - 4096);
			default: return CW'($urandom);
		endcase
	endfunction

	// Cursor placed near the particle most of the time so pushes happen
	function automatic particle_in_t rand_particle();
		particle_in_t p;
		int k;
		p.pos_x = any_coord(); p.pos_y = any_coord();
		p.vel_x = any_coord(); p.vel_y = any_coord();
		p.home_x = any_coord(); p.home_y = any_coord();
		p.touched_in = $urandom_range(0, 1);
		p.button_down = $urandom_range(0, 3) != 0;
		case ($urandom_range(0, 7))
			0: begin
				p.cursor_x = p.pos_x;
				p.cursor_y = p.pos_y;
			end
			1: begin
				p.cursor_x = any_coord();
				p.cursor_y = any_coord();
			end
			default: begin
				k = $urandom_range(0, 16);
				p.cursor_x = p.pos_x + CW'($signed($urandom_range(0, 1 << k))
					- (1 << (k - 1 < 0 ? 0 : k - 1)));
				p.cursor_y = p.pos_y + CW'($signed($urandom_range(0, 1 << k))
					- (1 << (k - 1 < 0 ? 0 : k - 1)));
			end
		endcase
		return p;
	endfunction

	initial begin
		particle_in_t p;
		logic signed [CW-1:0] mx, mn;
		mx = {1'b0, {(CW-1){1'b1}}};
		mn = {1'b1, {(CW-1){1'b0}}};
		arst_n = 0;
		cfg_valid = 0; cfg_index = CFG_MODE; cfg_data = 0;
		in_valid = 0;
		pos_x = 0; pos_y = 0; vel_x = 0; vel_y = 0; home_x = 0; home_y = 0;
		touched_in = 0; cursor_x = 0; cursor_y = 0; button_down = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: reset config (button-gated), extremes and zero distance
		for (int i = 0; i < 20; i++) begin
			p = rand_particle();
			case (i)
				0: p = '{mx, mx, mx, mx, mn, mn, 1'b0, mx, mx, 1'b1};
				1: p = '{mn, mn, mn, mn, mx, mx, 1'b1, mn, mn, 1'b1};
				2: p = '{0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 1'b1};
				3: p = '{0, 0, mx, mn, mx, mn, 1'b0, 1, 0, 1'b1};
				4: p = '{mx, mn, 0, 0, mn, mx, 1'b0, mn, mx, 1'b1};
				5: p = '{100, 100, 5, -5, 0, 0, 1'b1, 100, 100, 1'b0};
				6: p = '{0, 0, 0, 0, 0, 0, 1'b0, 1, 1, 1'b1};
				7: p = '{-256, 256, mx, mx, 0, 0, 1'b0, 256, -256, 1'b1};
				default: ;
			endcase
			send_particle(p);
		end

		// Config phases, extremes included; one with a long result hold
		for (int ph = 0; ph < 9; ph++) begin
			drain();
			case (ph)
				0: set_config(MODE_LATCH, 58982, 6554, 6400);
				1: set_config(MODE_RADIUS, 65536, 0, 0);
				2: set_config(MODE_RADIUS, 0, 65536, 6400);
				3: set_config(MODE_RADIUS, 131071, 131071, 32'hFFFF_FFFF);
				4: set_config(MODE_FIXED, 0, 0, 10000);
				5: set_config(MODE_BUTTON, 1, 1, 1);
				6: set_config(MODE_LATCH, 0, 131071, 32'hFFFF_FFFF);
				7: set_config(MODE_LATCH, 65536, 65536, 0);
				default: set_config(MODE_RADIUS, $urandom_range(0, 131071),
					$urandom_range(0, 131071), $urandom_range(0, 1 << 20));
			endcase
			if (ph == 3) hold_cycles = 300;
			idle_on = (ph % 3) != 1;
			for (int i = 0; i < 55; i++)
				send_particle(rand_particle());
		end

		idle_on = 1;
		drain();
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
